// ===== src/brcp_pkg.sv =====
package brcp_pkg;

    // Geometry
    localparam int unsigned SECTOR_BYTES = 512;
    localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned ID_BYTES     = 20;

    // Header request types
    localparam logic [31:0] TYPE_IN    = 32'd0;
    localparam logic [31:0] TYPE_OUT   = 32'd1;
    localparam logic [31:0] TYPE_FLUSH = 32'd4;
    localparam logic [31:0] TYPE_GETID = 32'd8;

    // Chain phase
    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_BODY   = 1'b1;

    // Operation kinds
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_SYNC  = 3'd3;
    localparam logic [2:0] OP_ID    = 3'd4;

    // Command codes
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_SYNC   = 3'd3;
    localparam logic [2:0] CMD_ID     = 3'd4;
    localparam logic [2:0] CMD_STATUS = 3'd5;
    localparam logic [2:0] CMD_FAULT  = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_IOERR  = 2'd1;
    localparam logic [1:0] ST_UNSUPP = 2'd2;

    // Configuration register indexes
    localparam logic CFG_READ_ONLY = 1'b0;
    localparam logic CFG_ID_LENGTH = 1'b1;

    localparam int unsigned S_TDATA_W = 192;
    localparam int unsigned M_TDATA_W = 200;
    localparam int unsigned CFG_W     = 8;

    // One result word
    typedef struct packed {
        logic        chain_end;
        logic [31:0] used_bytes;
        logic [1:0]  status_value;
        logic [63:0] disk_offset;
        logic [31:0] cmd_length;
        logic [63:0] cmd_addr;
        logic [2:0]  command;
    } result_t;

endpackage

// ===== src/block_request_chain_parser_unit.sv =====
// Channel | Dir | Handshake         | Payload
// s_      | in  | s_tvalid/s_tready | s_tdata, s_tuser (writable), s_tlast (last descriptor)
// m_      | out | m_tvalid/m_tready | m_tdata, m_tlast (request complete)
// cfg_    | in  | cfg_wr_en         | cfg_index, cfg_wdata
//
// One descriptor per cycle while s_tready is high. A taken descriptor's result goes to
// the result register, or to the skid entry while the output stalls. Chain state and
// result come from a single pass of compares and one 64-bit add; a two-entry output
// stage (result register, skid) holds results; s_tready drops only while the skid is full.
// aresetn is synchronous, active low; it clears chain state, configuration, output valids.
module block_request_chain_parser_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write port
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [brcp_pkg::CFG_W-1:0]     cfg_wdata,
    // descriptor stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // desc_addr[63:0], desc_len[95:64], hdr_type[127:96], hdr_sector[191:128]
    input  logic [brcp_pkg::S_TDATA_W-1:0] s_tdata,
    // desc_writable[0]
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // command[2:0], cmd_addr[66:3], cmd_length[98:67], disk_offset[162:99],
    // status_value[164:163], used_bytes[196:165], zero fill[199:197]
    output logic [brcp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import brcp_pkg::*;

    // configuration
    logic       read_only_reg;
    logic [7:0] id_length_reg;

    // chain state
    logic        phase_reg,           phase_next;
    logic [2:0]  operation_reg,       operation_next;
    logic        expect_writable_reg, expect_writable_next;
    logic [1:0]  status_reg,          status_next;
    logic [63:0] disk_pointer_reg,    disk_pointer_next;
    logic [31:0] used_total_reg,      used_total_next;

    // output stage
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    result_t res;

    // input fields
    logic [63:0] desc_addr;
    logic [31:0] desc_len;
    logic [31:0] hdr_type;
    logic [63:0] hdr_sector;
    logic        desc_wr;
    logic        accept;
    logic        out_free;
    logic        status_byte;
    logic [31:0] id_copy;

    assign desc_addr  = s_tdata[63:0];
    assign desc_len   = s_tdata[95:64];
    assign hdr_type   = s_tdata[127:96];
    assign hdr_sector = s_tdata[191:128];
    assign desc_wr    = s_tuser;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign status_byte = (desc_len == 32'd1) && desc_wr && s_tlast;

    // id copy length: min(id_length + 1, buffer length)
    always_comb begin
        id_copy = {24'd0, id_length_reg} + 32'd1;
        if (id_copy > desc_len) begin
            id_copy = desc_len;
        end
    end

    // per-descriptor decode and chain state update
    always_comb begin
        phase_next           = phase_reg;
        operation_next       = operation_reg;
        expect_writable_next = expect_writable_reg;
        status_next          = status_reg;
        disk_pointer_next    = disk_pointer_reg;
        used_total_next      = used_total_reg;
        res                  = '0;

        if (status_byte) begin
            res.command      = CMD_STATUS;
            res.cmd_addr     = desc_addr;
            res.status_value = (phase_reg == PH_HEADER) ? ST_IOERR : status_reg;
            res.used_bytes   = used_total_reg;
            res.chain_end    = 1'b1;
        end else begin
            if (phase_reg == PH_HEADER) begin
                phase_next = PH_BODY;
                if (desc_wr || desc_len != 32'(HEADER_BYTES)) begin
                    status_next = ST_IOERR;
                end else if (hdr_type == TYPE_IN) begin
                    operation_next       = OP_READ;
                    expect_writable_next = 1'b1;
                    disk_pointer_next    = hdr_sector << SECTOR_SHIFT;
                end else if (hdr_type == TYPE_OUT) begin
                    if (read_only_reg) begin
                        status_next = ST_IOERR;
                    end else begin
                        operation_next       = OP_WRITE;
                        expect_writable_next = 1'b0;
                        disk_pointer_next    = hdr_sector << SECTOR_SHIFT;
                    end
                end else if (hdr_type == TYPE_FLUSH) begin
                    if (hdr_sector != 64'd0) begin
                        status_next = ST_IOERR;
                    end else begin
                        operation_next       = OP_SYNC;
                        expect_writable_next = 1'b0;
                        res.command          = CMD_SYNC;
                    end
                end else if (hdr_type == TYPE_GETID) begin
                    operation_next       = OP_ID;
                    expect_writable_next = 1'b1;
                end else begin
                    status_next = ST_UNSUPP;
                end
            end else if (status_reg == ST_OK) begin
                // data descriptor, only checked while no error is pending
                if (desc_wr != expect_writable_reg) begin
                    status_next = ST_IOERR;
                end else if (operation_reg == OP_READ || operation_reg == OP_WRITE) begin
                    if (desc_len[SECTOR_SHIFT-1:0] != '0) begin
                        status_next = ST_IOERR;
                    end else begin
                        res.command       = (operation_reg == OP_READ) ? CMD_READ : CMD_WRITE;
                        res.cmd_addr      = desc_addr;
                        res.cmd_length    = desc_len;
                        res.disk_offset   = disk_pointer_reg;
                        disk_pointer_next = disk_pointer_reg + {32'd0, desc_len};
                        if (operation_reg == OP_READ) begin
                            used_total_next = used_total_reg + desc_len;
                        end
                    end
                end else if (operation_reg == OP_ID) begin
                    if (desc_len != 32'(ID_BYTES)) begin
                        status_next = ST_IOERR;
                    end else begin
                        res.command     = CMD_ID;
                        res.cmd_addr    = desc_addr;
                        res.cmd_length  = id_copy;
                        used_total_next = used_total_reg + id_copy;
                    end
                end
            end

            // chain ended without a status byte
            if (s_tlast) begin
                res              = '0;
                res.command      = CMD_FAULT;
                res.status_value = status_next;
                res.used_bytes   = used_total_next;
                res.chain_end    = 1'b1;
            end
        end

        // request complete: back to the header phase
        if (res.chain_end) begin
            phase_next           = PH_HEADER;
            operation_next       = OP_NONE;
            expect_writable_next = 1'b0;
            status_next          = ST_OK;
            disk_pointer_next    = '0;
            used_total_next      = '0;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_only_reg <= 1'b0;
            id_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_READ_ONLY: read_only_reg <= cfg_wdata[0];
                CFG_ID_LENGTH: id_length_reg <= cfg_wdata[7:0];
                default:       read_only_reg <= read_only_reg;
            endcase
        end
    end

    // chain state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HEADER;
            operation_reg       <= OP_NONE;
            expect_writable_reg <= 1'b0;
            status_reg          <= ST_OK;
            disk_pointer_reg    <= '0;
            used_total_reg      <= '0;
        end else if (accept) begin
            phase_reg           <= phase_next;
            operation_reg       <= operation_next;
            expect_writable_reg <= expect_writable_next;
            status_reg          <= status_next;
            disk_pointer_reg    <= disk_pointer_next;
            used_total_reg      <= used_total_next;
        end
    end

    // output stage: result register with a skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_free) begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && out_free) begin
            out_reg <= res;
        end else if (out_free && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
        if (accept && !out_free) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.chain_end;
    assign m_tdata  = {3'd0, out_reg.used_bytes, out_reg.status_value, out_reg.disk_offset,
                       out_reg.cmd_length, out_reg.cmd_addr, out_reg.command};

endmodule
